>>> sv/rrc_pkg.sv
// Package with shared constants for the rational reduce and compare core.
`timescale 1ns / 1ps

package rrc_pkg;

    localparam int PORT_W         = 32;
    localparam int DEN_W          = 31;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic CMD_REDUCE  = 1'b0;
    localparam logic CMD_COMPARE = 1'b1;

endpackage

>>> sv/rrc_addsub.sv
// Shared adder and subtractor used by the GCD, division and multiplication steps of the core.
`timescale 1ns / 1ps

module rrc_addsub #(
    parameter int WIDTH = rrc_pkg::VALUE_BITS_DEF
) (
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    input  logic             sub,
    output logic [WIDTH-1:0] sum,
    output logic             carry
);

    logic [WIDTH-1:0] b_eff;
    logic [WIDTH:0]   ext;

    assign b_eff = sub ? ~op_b : op_b;
    assign ext   = {1'b0, op_a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, sub};
    assign sum   = ext[WIDTH-1:0];
    assign carry = ext[WIDTH];

endmodule

>>> sv/rational_reduce_compare_core.sv
// Top level of the rational reduce and compare core with its sequencer and registers.
//
//   Channel   Handshake             Ports
//   -------   -------------------   ---------------------------------------------
//   command   start high, busy low  cmd, num_a, den_a, num_b, den_b
//   result    done for one cycle    red_num, red_den, is_less, is_greater, is_equal
//
// A reduce with a zero part, or a compare decided by the signs alone, answers in the next cycle.
// Other compares run two shift-and-add multiplications, then compare the two products.
// Other reduces run a binary GCD on the shared subtractor (its length is data
// dependent), then two restoring divisions, one for each part of the fraction.
// Reset clears the sequencer and the result strobe; the receiver cannot stall results.
`timescale 1ns / 1ps

module rational_reduce_compare_core #(
    parameter int VALUE_BITS = rrc_pkg::VALUE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cmd,
    input  logic [rrc_pkg::PORT_W-1:0]  num_a,
    input  logic [rrc_pkg::PORT_W-1:0]  den_a,
    input  logic [rrc_pkg::PORT_W-1:0]  num_b,
    input  logic [rrc_pkg::PORT_W-1:0]  den_b,
    output logic                        done,
    output logic [rrc_pkg::PORT_W-1:0]  red_num,
    output logic [rrc_pkg::DEN_W-1:0]   red_den,
    output logic                        is_less,
    output logic                        is_greater,
    output logic                        is_equal
);

    localparam int W  = VALUE_BITS;
    localparam int CW = $clog2(VALUE_BITS);
    localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [CW-1:0] LAST = CW'(VALUE_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_STRIP,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_FIN,
        S_MUL1,
        S_MUL2,
        S_CMP
    } state_t;

    state_t state_reg, state_next;

    logic [W-1:0]   x_reg, x_next, y_reg, y_next;
    logic [W-1:0]   rem_reg, rem_next, quo_reg, quo_next, div_reg, div_next;
    logic [W-1:0]   mna_reg, mna_next, mda_reg, mda_next, mnb_reg, mnb_next;
    logic [W-1:0]   qn_reg, qn_next;
    logic [2*W-1:0] p1_reg, p1_next;
    logic [CW-1:0]  cnt_reg, cnt_next, k_reg, k_next;
    logic           sign_reg, sign_next, neg_reg, neg_next, eq_reg, eq_next;
    logic           done_reg, done_next;
    logic [rrc_pkg::PORT_W-1:0] red_num_reg, red_num_next;
    logic [rrc_pkg::DEN_W-1:0]  red_den_reg, red_den_next;
    logic           lt_reg, lt_next, gt_reg, gt_next, eqo_reg, eqo_next;

    logic [W-1:0] na, da, nb, db;
    logic [W-1:0] mag_na, mag_da, mag_nb, mag_db;
    logic         a_zero, b_zero, a_neg, b_neg, a_pos, b_pos, raw_eq;

    logic [W-1:0]   op_a, op_b, sum;
    logic           sub, carry;
    logic [W-1:0]   shifted, nsat, dsat, nval;
    logic [2*W-1:0] p2;
    logic [rrc_pkg::PORT_W-1:0] num_ext;
    logic [rrc_pkg::DEN_W-1:0]  den_ext;

    assign na = num_a[W-1:0];
    assign da = den_a[W-1:0];
    assign nb = num_b[W-1:0];
    assign db = den_b[W-1:0];

    assign mag_na = na[W-1] ? (~na + 1'b1) : na;
    assign mag_da = da[W-1] ? (~da + 1'b1) : da;
    assign mag_nb = nb[W-1] ? (~nb + 1'b1) : nb;
    assign mag_db = db[W-1] ? (~db + 1'b1) : db;

    assign a_zero = (na == '0) || (da == '0);
    assign b_zero = (nb == '0) || (db == '0);
    assign a_neg  = !a_zero && (na[W-1] ^ da[W-1]);
    assign b_neg  = !b_zero && (nb[W-1] ^ db[W-1]);
    assign a_pos  = !a_zero && !a_neg;
    assign b_pos  = !b_zero && !b_neg;
    assign raw_eq = (na == nb) && (da == db);

    assign shifted = {rem_reg[W-2:0], quo_reg[W-1]};
    assign p2      = {rem_reg, quo_reg};

    rrc_addsub #(
        .WIDTH (W)
    ) u_addsub (
        .op_a  (op_a),
        .op_b  (op_b),
        .sub   (sub),
        .sum   (sum),
        .carry (carry)
    );

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        sub  = 1'b0;
        unique case (state_reg)
            S_GCD:
            begin
                op_a = x_reg;
                op_b = y_reg;
                sub  = 1'b1;
            end
            S_DIVN, S_DIVD:
            begin
                op_a = shifted;
                op_b = div_reg;
                sub  = 1'b1;
            end
            S_MUL1, S_MUL2:
            begin
                op_a = rem_reg;
                op_b = quo_reg[0] ? div_reg : '0;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    always_comb
    begin
        nsat = qn_reg[W-1] ? MAXV : qn_reg;
        dsat = quo_reg[W-1] ? MAXV : quo_reg;
        nval = sign_reg ? (~nsat + 1'b1) : nsat;
        num_ext = {rrc_pkg::PORT_W{nval[W-1]}};
        num_ext[W-1:0] = nval;
        den_ext = '0;
        den_ext[W-2:0] = dsat[W-2:0];
    end

    always_comb
    begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        div_next     = div_reg;
        mna_next     = mna_reg;
        mda_next     = mda_reg;
        mnb_next     = mnb_reg;
        qn_next      = qn_reg;
        p1_next      = p1_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        sign_next    = sign_reg;
        neg_next     = neg_reg;
        eq_next      = eq_reg;
        done_next    = 1'b0;
        red_num_next = red_num_reg;
        red_den_next = red_den_reg;
        lt_next      = lt_reg;
        gt_next      = gt_reg;
        eqo_next     = eqo_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mna_next  = mag_na;
                    mda_next  = mag_da;
                    mnb_next  = mag_nb;
                    sign_next = na[W-1] ^ da[W-1];
                    neg_next  = a_neg;
                    eq_next   = raw_eq;
                    cnt_next  = '0;
                    k_next    = '0;
                    if (cmd == rrc_pkg::CMD_REDUCE)
                    begin
                        if (a_zero)
                        begin
                            done_next    = 1'b1;
                            red_num_next = '0;
                            red_den_next = '0;
                            lt_next      = 1'b0;
                            gt_next      = 1'b0;
                            eqo_next     = 1'b0;
                        end
                        else
                        begin
                            x_next     = mag_na;
                            y_next     = mag_da;
                            state_next = S_STRIP;
                        end
                    end
                    else
                    begin
                        if ((a_neg != b_neg) || (a_zero != b_zero) || (a_zero && b_zero))
                        begin
                            done_next    = 1'b1;
                            red_num_next = '0;
                            red_den_next = '0;
                            lt_next      = (a_neg && !b_neg) || (a_zero && b_pos);
                            gt_next      = (a_pos && !b_pos) || (a_zero && b_neg);
                            eqo_next     = raw_eq;
                        end
                        else
                        begin
                            rem_next   = '0;
                            quo_next   = mag_na;
                            div_next   = mag_db;
                            state_next = S_MUL1;
                        end
                    end
                end
            end
            S_STRIP:
            begin
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    if (!y_reg[0])
                    begin
                        x_next = y_reg;
                        y_next = x_reg;
                    end
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (x_reg == '0)
                begin
                    div_next   = y_reg << k_reg;
                    rem_next   = '0;
                    quo_next   = mna_reg;
                    cnt_next   = '0;
                    state_next = S_DIVN;
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (carry)
                begin
                    x_next = sum;
                end
                else
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
            end
            S_DIVN, S_DIVD:
            begin
                rem_next = carry ? sum : shifted;
                quo_next = {quo_reg[W-2:0], carry};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next = '0;
                    if (state_reg == S_DIVN)
                    begin
                        qn_next    = {quo_reg[W-2:0], carry};
                        rem_next   = '0;
                        quo_next   = mda_reg;
                        state_next = S_DIVD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                done_next    = 1'b1;
                red_num_next = num_ext;
                red_den_next = den_ext;
                lt_next      = 1'b0;
                gt_next      = 1'b0;
                eqo_next     = 1'b0;
                state_next   = S_IDLE;
            end
            S_MUL1, S_MUL2:
            begin
                rem_next = {carry, sum[W-1:1]};
                quo_next = {sum[0], quo_reg[W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next = '0;
                    if (state_reg == S_MUL1)
                    begin
                        p1_next    = {carry, sum, quo_reg[W-1:1]};
                        rem_next   = '0;
                        quo_next   = mnb_reg;
                        div_next   = mda_reg;
                        state_next = S_MUL2;
                    end
                    else
                    begin
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP:
            begin
                done_next    = 1'b1;
                red_num_next = '0;
                red_den_next = '0;
                lt_next      = neg_reg ? (p1_reg > p2) : (p1_reg < p2);
                gt_next      = neg_reg ? (p1_reg < p2) : (p1_reg > p2);
                eqo_next     = eq_reg;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            x_reg       <= '0;
            y_reg       <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            div_reg     <= '0;
            mna_reg     <= '0;
            mda_reg     <= '0;
            mnb_reg     <= '0;
            qn_reg      <= '0;
            p1_reg      <= '0;
            cnt_reg     <= '0;
            k_reg       <= '0;
            sign_reg    <= 1'b0;
            neg_reg     <= 1'b0;
            eq_reg      <= 1'b0;
            done_reg    <= 1'b0;
            red_num_reg <= '0;
            red_den_reg <= '0;
            lt_reg      <= 1'b0;
            gt_reg      <= 1'b0;
            eqo_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            div_reg     <= div_next;
            mna_reg     <= mna_next;
            mda_reg     <= mda_next;
            mnb_reg     <= mnb_next;
            qn_reg      <= qn_next;
            p1_reg      <= p1_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
            sign_reg    <= sign_next;
            neg_reg     <= neg_next;
            eq_reg      <= eq_next;
            done_reg    <= done_next;
            red_num_reg <= red_num_next;
            red_den_reg <= red_den_next;
            lt_reg      <= lt_next;
            gt_reg      <= gt_next;
            eqo_reg     <= eqo_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign red_num    = red_num_reg;
    assign red_den    = red_den_reg;
    assign is_less    = lt_reg;
    assign is_greater = gt_reg;
    assign is_equal   = eqo_reg;

endmodule

>>> sv/rrc_check.sv
// Port-level assertion checker for the rational reduce and compare core, with its bind.
`timescale 1ns / 1ps

module rrc_check (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [rrc_pkg::PORT_W-1:0] red_num,
    input logic [rrc_pkg::DEN_W-1:0]  red_den,
    input logic                       is_less,
    input logic                       is_greater,
    input logic                       is_equal
);

    // A result is only shown once the sequencer is free again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // An accepted transaction either starts work or answers in the next cycle.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither started nor answered");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!(is_less && is_greater) && (!is_equal || (!is_less && !is_greater))))
        else $error("inconsistent order flags");

    a_zero_pair: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((red_num == '0) == (red_den == '0)))
        else $error("reduced numerator and denominator disagree on zero");

    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (is_less || is_greater || is_equal)) |-> (red_num == '0))
        else $error("compare result carries a numerator");

endmodule

bind rational_reduce_compare_core rrc_check u_rrc_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .red_num    (red_num),
    .red_den    (red_den),
    .is_less    (is_less),
    .is_greater (is_greater),
    .is_equal   (is_equal)
);

>>> bench/tb_rational_reduce_compare_core.sv
// Self-checking testbench for the rational reduce and compare core.
`timescale 1ns / 1ps

module tb_rational_reduce_compare_core;

    localparam int VALUE_BITS   = rrc_pkg::VALUE_BITS_DEF;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 6 * VALUE_BITS + 16;
    localparam int RANDOM_ITEMS = 550;

    localparam logic [rrc_pkg::PORT_W-1:0] MOST_NEG = {1'b1, {(rrc_pkg::PORT_W-1){1'b0}}};
    localparam logic [rrc_pkg::PORT_W-1:0] MOST_POS = {1'b0, {(rrc_pkg::PORT_W-1){1'b1}}};

    typedef struct packed {
        logic                       cmd;
        logic [rrc_pkg::PORT_W-1:0] num_a;
        logic [rrc_pkg::PORT_W-1:0] den_a;
        logic [rrc_pkg::PORT_W-1:0] num_b;
        logic [rrc_pkg::PORT_W-1:0] den_b;
    } rational_cmd_t;

    typedef struct packed {
        logic [rrc_pkg::PORT_W-1:0] red_num;
        logic [rrc_pkg::DEN_W-1:0]  red_den;
        logic                       is_less;
        logic                       is_greater;
        logic                       is_equal;
    } rational_result_t;

    class rational_scoreboard;
        rational_result_t expected_q[$];
        int               errors;

        function new();
            errors = 0;
        endfunction

        function longint widen(logic [rrc_pkg::PORT_W-1:0] raw);
            logic [63:0] t;
            t = {32'b0, raw};
            t = t << (64 - VALUE_BITS);
            return $signed(t) >>> (64 - VALUE_BITS);
        endfunction

        function longint unsigned magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function longint unsigned euclid(longint unsigned x, longint unsigned y);
            longint unsigned t;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        // Computes the result of one accepted transaction and queues it.
        function void note_command(rational_cmd_t c);
            longint           na, da, nb, db, maxv, sa, sb, pa, pb;
            longint unsigned  g, m, ma, mb;
            rational_result_t r;
            r    = '0;
            maxv = (longint'(1) << (VALUE_BITS - 1)) - 1;
            na   = widen(c.num_a);
            da   = widen(c.den_a);
            if (c.cmd == rrc_pkg::CMD_REDUCE)
            begin
                if (na != 0 && da != 0)
                begin
                    if (da < 0)
                    begin
                        na = -na;
                        da = -da;
                    end
                    g  = euclid(magnitude(na), magnitude(da));
                    na = na / longint'(g);
                    da = da / longint'(g);
                    if (na > maxv)
                        na = maxv;
                    if (na < -maxv)
                        na = -maxv;
                    if (da > maxv)
                        da = maxv;
                    r.red_num = na[rrc_pkg::PORT_W-1:0];
                    r.red_den = da[rrc_pkg::DEN_W-1:0];
                end
            end
            else
            begin
                nb = widen(c.num_b);
                db = widen(c.den_b);
                r.is_equal = (na == nb && da == db);
                if (da == 0)
                begin
                    na = 0;
                    da = 1;
                end
                if (db == 0)
                begin
                    nb = 0;
                    db = 1;
                end
                ma = magnitude(da);
                mb = magnitude(db);
                g  = euclid(ma, mb);
                m  = (ma / g) * mb;
                sa = longint'(m / ma);
                sb = longint'(m / mb);
                if (da < 0)
                    sa = -sa;
                if (db < 0)
                    sb = -sb;
                pa = na * sa;
                pb = nb * sb;
                r.is_less    = (pa < pb);
                r.is_greater = (pa > pb);
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(rational_result_t got);
            rational_result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.red_num !== want.red_num)
            begin
                $display("%0t: red_num expected %0d actual %0d", $time,
                         $signed(want.red_num), $signed(got.red_num));
                errors++;
            end
            if (got.red_den !== want.red_den)
            begin
                $display("%0t: red_den expected %0d actual %0d", $time,
                         want.red_den, got.red_den);
                errors++;
            end
            if (got.is_less !== want.is_less)
            begin
                $display("%0t: is_less expected %b actual %b", $time,
                         want.is_less, got.is_less);
                errors++;
            end
            if (got.is_greater !== want.is_greater)
            begin
                $display("%0t: is_greater expected %b actual %b", $time,
                         want.is_greater, got.is_greater);
                errors++;
            end
            if (got.is_equal !== want.is_equal)
            begin
                $display("%0t: is_equal expected %b actual %b", $time,
                         want.is_equal, got.is_equal);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             done;
    rational_cmd_t    cur;
    rational_result_t res;
    int               idle_cycles;
    bit               quiet_stretch;

    rational_scoreboard sb = new();

    rational_reduce_compare_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cur.cmd),
        .num_a      (cur.num_a),
        .den_a      (cur.den_a),
        .num_b      (cur.num_b),
        .den_b      (cur.den_b),
        .done       (done),
        .red_num    (res.red_num),
        .red_den    (res.red_den),
        .is_less    (res.is_less),
        .is_greater (res.is_greater),
        .is_equal   (res.is_equal)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(res);
            if (start && !busy)
                sb.note_command(cur);
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [rrc_pkg::PORT_W-1:0] signed_small(int unsigned hi);
        logic [rrc_pkg::PORT_W-1:0] v;
        v = $urandom_range(1, hi);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [rrc_pkg::PORT_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return signed_small(1);
            2: return MOST_POS;
            3: return MOST_NEG;
            4, 5: return $urandom();
            6, 7: return signed_small(1000);
            8: return signed_small(1 << 20);
            default: return $urandom_range(0, 1) ? MOST_NEG + 1 : MOST_POS - 1;
        endcase
    endfunction

    // Most transactions carry fractions with a shared factor so that the
    // reduction and the cross scaling do real work.
    function automatic rational_cmd_t random_command();
        rational_cmd_t              c;
        logic [rrc_pkg::PORT_W-1:0] k, j;
        c.cmd = $urandom_range(0, 1) ? rrc_pkg::CMD_COMPARE : rrc_pkg::CMD_REDUCE;
        k     = $urandom_range(1, 100000);
        c.num_a = k * signed_small(3000);
        c.den_a = k * signed_small(3000);
        c.num_b = pick_value();
        c.den_b = pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                c.num_b = $urandom_range(1, 100000) * signed_small(3000);
                c.den_b = $urandom_range(1, 100000) * signed_small(3000);
            end
            3:
            begin
                c.num_b = c.num_a;
                c.den_b = c.den_a;
            end
            4:
            begin
                c.num_a = signed_small(20000);
                c.den_a = signed_small(20000);
                j       = signed_small(50000);
                c.num_b = c.num_a * j;
                c.den_b = c.den_a * j;
            end
            5, 6, 7:
            begin
                c.num_a = pick_value();
                c.den_a = pick_value();
            end
            8:
            begin
                c.num_a = $urandom_range(0, 1) ? '0 : c.num_a;
                c.den_a = $urandom_range(0, 1) ? '0 : c.den_a;
                c.den_b = $urandom_range(0, 1) ? '0 : c.den_b;
            end
            default:
            begin
                c.num_a = $urandom();
                c.den_a = $urandom();
                c.num_b = $urandom();
                c.den_b = $urandom();
            end
        endcase
        return c;
    endfunction

    task automatic issue_command(rational_cmd_t c);
        int gap;
        gap = quiet_stretch ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur   <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        if ($urandom_range(0, 39) == 0)
            quiet_stretch = !quiet_stretch;
    endtask

    task automatic issue_fraction(logic op,
                                  logic [rrc_pkg::PORT_W-1:0] na,
                                  logic [rrc_pkg::PORT_W-1:0] da,
                                  logic [rrc_pkg::PORT_W-1:0] nb,
                                  logic [rrc_pkg::PORT_W-1:0] db);
        rational_cmd_t c;
        c = '{cmd: op, num_a: na, den_a: da, num_b: nb, den_b: db};
        issue_command(c);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        cur           = '0;
        idle_cycles   = 0;
        quiet_stretch = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        issue_fraction(rrc_pkg::CMD_REDUCE, 0, 5, 0, 0);
        issue_fraction(rrc_pkg::CMD_REDUCE, 7, 0, 0, 0);
        issue_fraction(rrc_pkg::CMD_REDUCE, 0, 0, 0, 0);
        issue_fraction(rrc_pkg::CMD_REDUCE, 12, 8, 0, 0);
        issue_fraction(rrc_pkg::CMD_REDUCE, 6, -4, 0, 0);
        issue_fraction(rrc_pkg::CMD_REDUCE, -6, -4, 0, 0);
        issue_fraction(rrc_pkg::CMD_REDUCE, MOST_NEG, 2, 0, 0);
        issue_fraction(rrc_pkg::CMD_REDUCE, MOST_NEG, -1, 0, 0);
        issue_fraction(rrc_pkg::CMD_REDUCE, 1, MOST_NEG, 0, 0);
        issue_fraction(rrc_pkg::CMD_REDUCE, MOST_NEG, MOST_NEG, 0, 0);
        issue_fraction(rrc_pkg::CMD_REDUCE, MOST_POS, -1, MOST_NEG, MOST_NEG);
        issue_fraction(rrc_pkg::CMD_REDUCE, -1, MOST_POS, 0, 0);
        issue_fraction(rrc_pkg::CMD_REDUCE, MOST_NEG, 6, 0, 0);
        issue_fraction(rrc_pkg::CMD_COMPARE, 3, 4, 3, 4);
        issue_fraction(rrc_pkg::CMD_COMPARE, 1, 2, 2, 4);
        issue_fraction(rrc_pkg::CMD_COMPARE, 5, 0, 0, 0);
        issue_fraction(rrc_pkg::CMD_COMPARE, 5, 0, -3, 7);
        issue_fraction(rrc_pkg::CMD_COMPARE, -1, 3, 1, 3);
        issue_fraction(rrc_pkg::CMD_COMPARE, MOST_POS, MOST_POS - 1,
                       MOST_POS - 1, MOST_POS - 2);
        issue_fraction(rrc_pkg::CMD_COMPARE, MOST_NEG, 1, MOST_POS, 1);
        issue_fraction(rrc_pkg::CMD_COMPARE, MOST_NEG, MOST_NEG, 1, 1);
        issue_fraction(rrc_pkg::CMD_COMPARE, 1, MOST_NEG, -1, MOST_POS);
        issue_fraction(rrc_pkg::CMD_COMPARE, 2, -3, -2, 3);
        issue_fraction(rrc_pkg::CMD_COMPARE, 0, 0, 0, 0);

        repeat (RANDOM_ITEMS)
            issue_command(random_command());
        start <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
